/* src/bfs_pkg.sv */
// Shared types, constants and bit-counting helpers for the bitmap find-and-select block.
`timescale 1ns / 1ps

package bfs_pkg;

    // Default row length in slot bits.
    localparam int COLS_DEFAULT = 256;

    // Width of one stored word of the row.
    localparam int WORD_BITS = 64;

    // Value of the span count register after reset.
    localparam logic [7:0] SPAN_RESET = 8'd1;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_FIND   = 2'd1,
        OP_SELECT = 2'd2,
        OP_SPAN   = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_NTH  = 5'b00100,
        S_SPAN = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    // Number of set bits in a word.
    function automatic logic [6:0] popcount64(input logic [WORD_BITS-1:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int b = 0; b < WORD_BITS; b++) begin
            n = n + {6'd0, v[b]};
        end
        return n;
    endfunction

    // Index of the lowest set bit; zero when the word is empty.
    function automatic logic [5:0] lowest64(input logic [WORD_BITS-1:0] v);
        logic [5:0] idx;
        idx = 6'd0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (v[b]) begin
                idx = 6'(b);
            end
        end
        return idx;
    endfunction

endpackage

/* src/bfs_row_mem.sv */
// Row storage: one synchronous word memory with per-word valid bits and the reset image.
`timescale 1ns / 1ps

module bfs_row_mem #(
    parameter int COLS      = bfs_pkg::COLS_DEFAULT,
    parameter int ROW_WORDS = (bfs_pkg::COLS_DEFAULT + 63) / 64,
    parameter int WAW       = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [WAW-1:0]                 i_rd_addr,
    input  logic                           i_wr_en,
    input  logic [WAW-1:0]                 i_wr_addr,
    input  logic [bfs_pkg::WORD_BITS-1:0]  i_wr_data,
    output logic [bfs_pkg::WORD_BITS-1:0]  o_rd_word
);

    localparam int REM = COLS % bfs_pkg::WORD_BITS;

    logic [bfs_pkg::WORD_BITS-1:0] mem [ROW_WORDS];
    logic [ROW_WORDS-1:0]          r_vld;
    logic [bfs_pkg::WORD_BITS-1:0] r_rd_data;
    logic                          r_rd_vld;
    logic [WAW-1:0]                r_rd_addr;

    // Bits of a word that lie inside the row; this is also the word's reset value.
    function automatic logic [bfs_pkg::WORD_BITS-1:0] valid_mask(input logic [WAW-1:0] w);
        logic [bfs_pkg::WORD_BITS-1:0] m;
        m = '1;
        if (REM != 0 && w == WAW'(ROW_WORDS - 1)) begin
            m = (64'd1 << REM) - 64'd1;
        end
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data & valid_mask(i_wr_addr);
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // A word never written since reset reads as its reset image.
    assign o_rd_word = r_rd_vld ? r_rd_data : valid_mask(r_rd_addr);

endmodule

/* src/bitmap_find_and_select_core.sv */
// Top level of the bitmap find-and-select block: sequencer, result register, span register.
`timescale 1ns / 1ps

// The block keeps one row of COLS slot bits in a word memory, all bits set after reset.
// Input channel (i_valid / o_ready) carries one operation word: write a 64-bit word,
// find the first set bit from a position with wrap, select the rank-th set bit, or set
// the span of bits after an anchor. Every accepted word yields exactly one result word
// on the output channel (o_valid / i_ready): found flag and the low 8 bits of the slot.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and loads the
// 8-bit span count; the user must write it only while the block is idle, and the block
// does not enforce this. One operation is in flight at a time; o_ready is high only
// while the sequencer idles. On the way from acceptance to a result in the output
// register, a write goes straight to the hold state; a find examines one memory word
// per cycle, the start word twice; a select scans one to W = (COLS+63)/64 words and on a
// hit takes six halving steps that locate the bit inside the word; a set span reads and
// rewrites each word it touches. The sequencer returns to idle as a result enters the
// output register, and only then accepts the next word. The memory's single read port
// and registered read set the one word per cycle.
// Reset clears the valid bits of the memory, so every word reads as all ones (bits past
// COLS cleared) at once; no clearing pass is needed. The span count returns to 1.
// The output register holds a finished result while the receiver stalls; the block may
// meanwhile accept and work on the next word, and waits only if a second result is due.

module bitmap_find_and_select_core #(
    parameter int COLS = bfs_pkg::COLS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // operation words
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [1:0]  i_word_address,
    input  logic [63:0] i_word_value,
    input  logic [7:0]  i_position,
    input  logic [7:0]  i_rank,
    // result words
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [7:0]  o_slot_index,
    // span count register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_span_count
);

    localparam int ROW_WORDS = (COLS + 63) / 64;
    // Slot index width, never below 7 so that the word index keeps at least one bit.
    localparam int SW  = ($clog2(COLS) > 7) ? $clog2(COLS) : 7;
    localparam int WAW = SW - 6;
    // Width for position arithmetic: holds position + span and COLS itself.
    localparam int PW  = (SW >= 9) ? SW + 1 : 10;
    localparam int CW  = $clog2(ROW_WORDS + 1);

    localparam logic [WAW-1:0] LAST_W = WAW'(ROW_WORDS - 1);

    // Sequencer state.
    bfs_pkg::t_state r_state, n_state;
    bfs_pkg::t_op    r_op, n_op;
    logic [WAW-1:0]  r_word, n_word;     // word whose data the memory presents
    logic [CW-1:0]   r_cnt, n_cnt;       // words examined so far
    logic            r_first, n_first;   // first word of a find or a span
    logic [5:0]      r_off, n_off;       // start bit inside the first find word
    logic [7:0]      r_left, n_left;     // set bits still to skip for select
    logic [63:0]     r_nword, n_nword;   // select: remaining window of the hit word
    logic [5:0]      r_nbase, n_nbase;   // select: bit offset of that window
    logic [2:0]      r_step, n_step;     // select: halving step
    logic [5:0]      r_lo, n_lo;         // span: first bit inside its word
    logic [5:0]      r_hi, n_hi;         // span: last bit inside its word
    logic [WAW-1:0]  r_whi, n_whi;       // span: last word touched

    // Finished result waiting for the output register.
    logic            r_res_found, n_res_found;
    logic [7:0]      r_res_slot, n_res_slot;

    // Output register.
    logic            r_out_valid, n_out_valid;
    logic            r_out_found, n_out_found;
    logic [7:0]      r_out_slot, n_out_slot;

    logic [7:0]      r_span;

    // Memory port.
    logic            w_rd_en, w_wr_en;
    logic [WAW-1:0]  w_rd_addr, w_wr_addr;
    logic [63:0]     w_wr_data, w_rd_word;

    // Decoded input fields.
    logic            w_accept;
    logic [PW-1:0]   w_pos, w_lo, w_hi_raw, w_last, w_start, w_addr;
    logic            w_span_empty;
    logic [SW-1:0]   w_start_s, w_lo_s, w_last_s;

    // Per-cycle datapath.
    logic [WAW-1:0]  w_next_word;
    logic [63:0]     w_find_bits;
    logic [6:0]      w_pc;
    logic [5:0]      w_half;
    logic [6:0]      w_half_cnt;
    logic            w_in_low;
    logic [5:0]      w_lo_off, w_hi_off;
    logic [63:0]     w_span_mask;

    // Slot number of a bit, kept to its low 8 bits.
    function automatic logic [7:0] make_slot(input logic [WAW-1:0] w, input logic [5:0] b);
        logic [WAW+7:0] t;
        t = {2'b00, w, b};
        return t[7:0];
    endfunction

    bfs_row_mem #(
        .COLS      (COLS),
        .ROW_WORDS (ROW_WORDS),
        .WAW       (WAW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_word (w_rd_word)
    );

    assign o_ready     = (r_state == bfs_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;

    // Input decoding. A find start past the row end searches from slot zero. A span
    // covers position+1 up to position+span-1, clipped at the last slot of the row.
    assign w_pos        = PW'(i_position);
    assign w_start      = (w_pos < PW'(COLS)) ? w_pos : '0;
    assign w_start_s    = w_start[SW-1:0];
    assign w_lo         = w_pos + PW'(1);
    assign w_hi_raw     = w_pos + PW'(r_span) - PW'(1);
    assign w_last       = (w_hi_raw >= PW'(COLS)) ? PW'(COLS - 1) : w_hi_raw;
    assign w_lo_s       = w_lo[SW-1:0];
    assign w_last_s     = w_last[SW-1:0];
    assign w_span_empty = (r_span < 8'd2) || (w_lo >= PW'(COLS));
    assign w_addr       = PW'(i_word_address);

    // Scan datapath on the word the memory presents.
    assign w_next_word = (r_word == LAST_W) ? '0 : r_word + WAW'(1);
    assign w_find_bits = r_first ? (w_rd_word & ({64{1'b1}} << r_off)) : w_rd_word;
    assign w_pc        = bfs_pkg::popcount64(w_rd_word);

    // Select halving: count the set bits in the low half of the current window.
    assign w_half     = 6'd32 >> r_step;
    assign w_half_cnt = bfs_pkg::popcount64(r_nword & ((64'd1 << w_half) - 64'd1));
    assign w_in_low   = ({1'b0, r_left} < {2'b00, w_half_cnt});

    // Span mask for the current word.
    assign w_lo_off    = r_first ? r_lo : 6'd0;
    assign w_hi_off    = (r_word == r_whi) ? r_hi : 6'd63;
    assign w_span_mask = ({64{1'b1}} << w_lo_off) & ({64{1'b1}} >> (6'd63 - w_hi_off));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_first     = r_first;
        n_off       = r_off;
        n_left      = r_left;
        n_nword     = r_nword;
        n_nbase     = r_nbase;
        n_step      = r_step;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_whi       = r_whi;
        n_res_found = r_res_found;
        n_res_slot  = r_res_slot;
        n_out_valid = r_out_valid && !i_ready;
        n_out_found = r_out_found;
        n_out_slot  = r_out_slot;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_word;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_word;
        w_wr_data   = w_rd_word;

        unique case (r_state)
            bfs_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op        = bfs_pkg::t_op'(i_op);
                    n_res_found = 1'b0;
                    n_res_slot  = 8'd0;
                    unique case (bfs_pkg::t_op'(i_op))
                        bfs_pkg::OP_WRITE: begin
                            // Words past the row end are ignored.
                            if (w_addr < PW'(ROW_WORDS)) begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = w_addr[WAW-1:0];
                                w_wr_data = i_word_value;
                            end
                            n_state = bfs_pkg::S_HOLD;
                        end
                        bfs_pkg::OP_FIND: begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_start_s[SW-1:6];
                            n_word    = w_start_s[SW-1:6];
                            n_off     = w_start_s[5:0];
                            n_first   = 1'b1;
                            n_cnt     = '0;
                            n_state   = bfs_pkg::S_SCAN;
                        end
                        bfs_pkg::OP_SELECT: begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                            n_word    = '0;
                            n_left    = i_rank;
                            n_cnt     = '0;
                            n_state   = bfs_pkg::S_SCAN;
                        end
                        bfs_pkg::OP_SPAN: begin
                            if (w_span_empty) begin
                                n_state = bfs_pkg::S_HOLD;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = w_lo_s[SW-1:6];
                                n_word    = w_lo_s[SW-1:6];
                                n_lo      = w_lo_s[5:0];
                                n_hi      = w_last_s[5:0];
                                n_whi     = w_last_s[SW-1:6];
                                n_first   = 1'b1;
                                n_state   = bfs_pkg::S_SPAN;
                            end
                        end
                        default: n_state = bfs_pkg::S_HOLD;
                    endcase
                end
            end

            bfs_pkg::S_SCAN: begin
                if (r_op == bfs_pkg::OP_FIND) begin
                    // The start word comes round twice: first from the start bit up,
                    // then whole, which can only hit below the start bit.
                    if (|w_find_bits) begin
                        n_res_found = 1'b1;
                        n_res_slot  = make_slot(r_word, bfs_pkg::lowest64(w_find_bits));
                        n_state     = bfs_pkg::S_HOLD;
                    end else if (r_cnt == CW'(ROW_WORDS)) begin
                        n_state = bfs_pkg::S_HOLD;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_next_word;
                        n_word    = w_next_word;
                        n_cnt     = r_cnt + CW'(1);
                        n_first   = 1'b0;
                    end
                end else begin
                    if ({1'b0, r_left} < {2'b00, w_pc}) begin
                        n_nword = w_rd_word;
                        n_nbase = 6'd0;
                        n_step  = 3'd0;
                        n_state = bfs_pkg::S_NTH;
                    end else if (r_cnt == CW'(ROW_WORDS - 1)) begin
                        n_state = bfs_pkg::S_HOLD;
                    end else begin
                        n_left    = r_left - {1'b0, w_pc};
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_next_word;
                        n_word    = w_next_word;
                        n_cnt     = r_cnt + CW'(1);
                    end
                end
            end

            bfs_pkg::S_NTH: begin
                if (!w_in_low) begin
                    n_left  = r_left - {1'b0, w_half_cnt};
                    n_nword = r_nword >> w_half;
                    n_nbase = r_nbase + w_half;
                end
                if (r_step == 3'd5) begin
                    n_res_found = 1'b1;
                    n_res_slot  = make_slot(r_word, w_in_low ? r_nbase : r_nbase + w_half);
                    n_state     = bfs_pkg::S_HOLD;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end

            bfs_pkg::S_SPAN: begin
                // Write back the word with its part of the span set, and fetch the
                // next word in the same cycle; the two never address the same entry.
                w_wr_en   = 1'b1;
                w_wr_addr = r_word;
                w_wr_data = w_rd_word | w_span_mask;
                if (r_word == r_whi) begin
                    n_state = bfs_pkg::S_HOLD;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_word + WAW'(1);
                    n_word    = r_word + WAW'(1);
                    n_first   = 1'b0;
                end
            end

            bfs_pkg::S_HOLD: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_slot  = r_res_slot;
                    n_state     = bfs_pkg::S_IDLE;
                end
            end

            default: n_state = bfs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_span      <= bfs_pkg::SPAN_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_span <= i_cfg_span_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_word      <= n_word;
        r_cnt       <= n_cnt;
        r_first     <= n_first;
        r_off       <= n_off;
        r_left      <= n_left;
        r_nword     <= n_nword;
        r_nbase     <= n_nbase;
        r_step      <= n_step;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_whi       <= n_whi;
        r_res_found <= n_res_found;
        r_res_slot  <= n_res_slot;
        r_out_found <= n_out_found;
        r_out_slot  <= n_out_slot;
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_slot_index = r_out_slot;

endmodule

/* src/bfs_checker.sv */
// Port-level checker for the bitmap find-and-select block, bound to its top level.
`timescale 1ns / 1ps

module bfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic [7:0]  o_slot_index
);

    // A result word that is stalled stays, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_slot_index))
        else $error("stalled result word changed or vanished");

    // A miss or a non-search operation reports slot zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_slot_index == 8'd0)
        else $error("result without a hit carries a nonzero slot");

    // One operation at a time: an accepted word closes the input for the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted while an operation was in flight");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present right after reset");

endmodule

bind bitmap_find_and_select_core bfs_checker u_bfs_checker (.*);
